@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL.
// Expects signals clk and arst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
else $error(msg);

`endif

@@ sv/tcf_pkg.sv @@
// Package for the two-class oldest-first FIFO: sizes, codes, control structs.
// No dependencies.
`default_nettype none

package tcf_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int STAMP_W     = 27;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		CMD_ENQ     = 2'd0,
		CMD_DEQ_ANY = 2'd1,
		CMD_DEQ_A   = 2'd2,
		CMD_DEQ_B   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		CLASS_A    = 2'd0,
		CLASS_B    = 2'd1,
		CLASS_NONE = 2'd2
	} rclass_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// queue control from the command decoder
	typedef struct packed {
		logic push;
		logic pop;
	} q_ctrl_t;

	// queue occupancy flags back to the decoder
	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

endpackage

`default_nettype wire

@@ sv/two_class_fifo_oldest_first_top.sv @@
// Top level of the two-class FIFO with oldest-first dequeue.
// Depends on tcf_pkg, tcf_queue (and tcf_cell), assert_macros.svh.
//
// Usage
//  - Command channel: a transaction is taken at a rising edge with start high
//    and busy low. busy never rises: a command is taken every cycle.
//    command: 0 enqueue, 1 dequeue older head of either class (A on a tie),
//    2 dequeue class A, 3 dequeue class B. entry_class and arrival_stamp
//    matter only for enqueue.
//  - Result channel: each command gives exactly one result transaction, shown
//    for one cycle with done high, in the cycle after the command is taken.
//    Throughput 1 command per cycle; the figure is set by
//    the single result register behind the decoder and the head compare.
//  - Each class queue is a row of QUEUE_DEPTH cells, head in cell 0. A pop
//    shifts the whole row one cell towards the head; a push
//    writes the cell picked by the fill count.
//  - Enqueue into a full queue drops the entry (status full); dequeue from
//    an empty queue returns class none, stamp 0, status empty.
//  - Reset (arst_n low) empties both queues and clears done; cell contents
//    are not reset and are never read before being written.
//  - The receiver cannot stall: results must be taken as they come.
`default_nettype none

module two_class_fifo_oldest_first_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [1:0]                  command,
	input  wire logic                        entry_class,
	input  wire logic [tcf_pkg::STAMP_W-1:0] arrival_stamp,
	output logic                             done,
	output logic      [1:0]                  result_class,
	output logic      [tcf_pkg::STAMP_W-1:0] result_stamp,
	output logic      [1:0]                  status
);
	import tcf_pkg::*;
	`include "assert_macros.svh"

	logic               accept;
	q_ctrl_t            ctrl_a, ctrl_b;
	q_stat_t            stat_a, stat_b;
	logic [STAMP_W-1:0] head_a, head_b;
	logic               take_a, take_b, a_older;
	rclass_t            res_class;
	logic [STAMP_W-1:0] res_stamp;
	status_t            res_status;

	// result register
	logic               done_q;
	rclass_t            class_q;
	logic [STAMP_W-1:0] stamp_q;
	status_t            status_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	tcf_queue u_queue_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl_a),
		.push_stamp(arrival_stamp),
		.head_stamp(head_a),
		.stat      (stat_a)
	);

	tcf_queue u_queue_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl_b),
		.push_stamp(arrival_stamp),
		.head_stamp(head_b),
		.stat      (stat_b)
	);

	// tie goes to class A
	assign a_older = (head_a <= head_b);

	// command decode: which queue moves, and the result of this transaction
	always_comb begin
		ctrl_a     = '0;
		ctrl_b     = '0;
		take_a     = 1'b0;
		take_b     = 1'b0;
		res_status = ST_OK;
		if (accept) begin
			unique case (cmd_t'(command))
				CMD_ENQ: begin
					if (!entry_class) begin
						if (stat_a.full) res_status = ST_FULL;
						else             ctrl_a.push = 1'b1;
					end else begin
						if (stat_b.full) res_status = ST_FULL;
						else             ctrl_b.push = 1'b1;
					end
				end
				CMD_DEQ_ANY: begin
					priority if (stat_a.empty && stat_b.empty) begin
						res_status = ST_EMPTY;
					end else if (stat_a.empty) begin
						take_b = 1'b1;
					end else if (stat_b.empty) begin
						take_a = 1'b1;
					end else if (a_older) begin
						take_a = 1'b1;
					end else begin
						take_b = 1'b1;
					end
				end
				CMD_DEQ_A: begin
					if (stat_a.empty) res_status = ST_EMPTY;
					else              take_a = 1'b1;
				end
				CMD_DEQ_B: begin
					if (stat_b.empty) res_status = ST_EMPTY;
					else              take_b = 1'b1;
				end
				default: res_status = ST_OK;
			endcase
		end
		ctrl_a.pop = take_a;
		ctrl_b.pop = take_b;
	end

	always_comb begin
		priority if (take_a) begin
			res_class = CLASS_A;
			res_stamp = head_a;
		end else if (take_b) begin
			res_class = CLASS_B;
			res_stamp = head_b;
		end else begin
			res_class = CLASS_NONE;
			res_stamp = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			class_q  <= res_class;
			stamp_q  <= res_stamp;
			status_q <= res_status;
		end
	end

	assign done         = done_q;
	assign result_class = class_q;
	assign result_stamp = stamp_q;
	assign status       = status_q;

	// every taken command yields a result in the next cycle
	`ASSERT_NEXT(a_result_follows, accept, done, "command taken without a result")
	// a full status comes only from an enqueue
	`ASSERT_IMPL(a_full_from_enq, done && (status == ST_FULL),
		$past(command) == CMD_ENQ, "full status on a dequeue")
	// never push into a full queue nor pop an empty one
	`ASSERT_IMPL(a_queue_bounds,
		!(ctrl_a.push && stat_a.full) && !(ctrl_b.push && stat_b.full)
		&& !(ctrl_a.pop && stat_a.empty) && !(ctrl_b.pop && stat_b.empty), 1'b1,
		"queue overflow or underflow")
	// at most one queue moves per command
	`ASSERT_IMPL(a_one_queue, accept,
		$countones({ctrl_a.push, ctrl_a.pop, ctrl_b.push, ctrl_b.pop}) <= 1,
		"more than one queue moved")

endmodule

`default_nettype wire

@@ sv/tcf_cell.sv @@
// One storage cell of a queue row: holds a stamp, loads a new one or takes its
// neighbour's on a shift. Depends on tcf_pkg.
`default_nettype none

module tcf_cell (
	input  wire logic                        clk,
	input  wire logic                        load_en,
	input  wire logic                        shift_en,
	input  wire logic [tcf_pkg::STAMP_W-1:0] new_stamp,
	input  wire logic [tcf_pkg::STAMP_W-1:0] next_stamp,
	output logic      [tcf_pkg::STAMP_W-1:0] stamp
);
	import tcf_pkg::*;

	logic [STAMP_W-1:0] stamp_q;

	// payload only, no reset
	always_ff @(posedge clk) begin
		if (load_en) begin
			stamp_q <= new_stamp;
		end else if (shift_en) begin
			stamp_q <= next_stamp;
		end
	end

	assign stamp = stamp_q;

endmodule

`default_nettype wire

@@ sv/tcf_queue.sv @@
// One class queue: a row of tcf_cell with the head fixed at cell 0 and a fill
// count. Depends on tcf_pkg and tcf_cell.
`default_nettype none

module tcf_queue (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire tcf_pkg::q_ctrl_t            ctrl,
	input  wire logic [tcf_pkg::STAMP_W-1:0] push_stamp,
	output logic      [tcf_pkg::STAMP_W-1:0] head_stamp,
	output tcf_pkg::q_stat_t                 stat
);
	import tcf_pkg::*;

	logic [CNT_W-1:0]   count_q;
	logic [STAMP_W-1:0] cell_stamp [QUEUE_DEPTH];

	// push lands in the first free cell; pop shifts the row towards cell 0
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic [STAMP_W-1:0] nxt;
		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign nxt = cell_stamp[i];
		end else begin : g_mid
			assign nxt = cell_stamp[i + 1];
		end
		tcf_cell u_cell (
			.clk       (clk),
			.load_en   (ctrl.push && (count_q == CNT_W'(i))),
			.shift_en  (ctrl.pop),
			.new_stamp (push_stamp),
			.next_stamp(nxt),
			.stamp     (cell_stamp[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			if (ctrl.push) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctrl.pop) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	assign head_stamp = cell_stamp[0];
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CNT_W'(QUEUE_DEPTH));

endmodule

`default_nettype wire

@@ sim/two_class_fifo_oldest_first_top_test.sv @@
// Self-checking testbench for two_class_fifo_oldest_first_top: a directed opening, then random
// command traffic checked against an in-bench model of the two class queues.
// Depends on tcf_pkg and the RTL of the block.

module two_class_fifo_oldest_first_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tcf_pkg::*;

	// entry_class encoding on the command side
	localparam logic ENTRY_A = 1'b0;
	localparam logic ENTRY_B = 1'b1;

	localparam int unsigned TOTAL_CMDS     = 650;
	localparam int unsigned PHASE1_START   = 216;  // sender idles 50 % from here
	localparam int unsigned PHASE2_START   = 433;  // no idling from here
	localparam int unsigned IDLE_PCT_P0    = 22;
	localparam int unsigned IDLE_PCT_P1    = 50;
	localparam int unsigned IDLE_PCT_P2    = 0;
	localparam int unsigned WATCHDOG_LIMIT = 500;  // cycles with no transaction at all
	localparam int unsigned END_SETTLE     = 8;    // spare settle time after the last result
	localparam int unsigned MAX_REPORTS    = 10;

	localparam logic [STAMP_W-1:0] STAMP_MAX_DATE = 27'd99991231;
	localparam logic [STAMP_W-1:0] STAMP_ALL_ONES = '1;

	// one pending command transaction, with the idling it is to see before it
	typedef struct {
		cmd_t                op;
		logic                cls;
		logic [STAMP_W-1:0]  stamp;
		int unsigned         idle_pct;
		bit                  wait_drain;
	} queue_cmd_t;

	// what the block should report for one command
	typedef struct {
		rclass_t             rclass;
		logic [STAMP_W-1:0]  stamp;
		status_t             st;
	} queue_result_t;

	logic                clk;
	logic                arst_n        = 1'b0;
	logic                start         = 1'b0;
	logic [1:0]          command       = CMD_ENQ;
	logic                entry_class   = ENTRY_A;
	logic [STAMP_W-1:0]  arrival_stamp = '0;
	logic                busy;
	logic                done;
	logic [1:0]          result_class;
	logic [STAMP_W-1:0]  result_stamp;
	logic [1:0]          status;

	queue_cmd_t          cmd_backlog[$];
	queue_result_t       expected_results[$];

	// model of the two class queues: front is the head
	logic [STAMP_W-1:0]  a_line[$];
	logic [STAMP_W-1:0]  b_line[$];

	bit                  cmd_taken   = 1'b0;
	int unsigned         idle_cycles = 0;
	int unsigned         fault_count = 0;
	int unsigned         n_cmds      = 0;
	int unsigned         n_results   = 0;
	int unsigned         n_stored    = 0;
	int unsigned         n_dropped   = 0;
	int unsigned         n_popped    = 0;
	int unsigned         n_empty     = 0;
	int unsigned         n_ties      = 0;

	two_class_fifo_oldest_first_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.command       (command),
		.entry_class   (entry_class),
		.arrival_stamp (arrival_stamp),
		.done          (done),
		.result_class  (result_class),
		.result_stamp  (result_stamp),
		.status        (status)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Queue model. Applies one command to a_line/b_line and returns the
	// result the block owes for it. Dequeue-any takes the older head,
	// class A on equal stamps; a lone non-empty queue is simply taken.
	// ------------------------------------------------------------------
	function automatic queue_result_t predict_queue_op(cmd_t op, logic cls,
			logic [STAMP_W-1:0] stamp);
		queue_result_t r;
		logic          pick_a;
		logic          pick_b;
		r.rclass = CLASS_NONE;
		r.stamp  = '0;
		r.st     = ST_OK;
		pick_a   = 1'b0;
		pick_b   = 1'b0;
		case (op)
		CMD_ENQ: begin
			if (cls == ENTRY_A) begin
				if (a_line.size() < QUEUE_DEPTH)
					a_line.push_back(stamp);
				else
					r.st = ST_FULL;
			end else begin
				if (b_line.size() < QUEUE_DEPTH)
					b_line.push_back(stamp);
				else
					r.st = ST_FULL;
			end
		end
		CMD_DEQ_ANY: begin
			if (a_line.size() == 0 && b_line.size() == 0) begin
				r.st = ST_EMPTY;
			end else if (a_line.size() == 0) begin
				pick_b = 1'b1;
			end else if (b_line.size() == 0) begin
				pick_a = 1'b1;
			end else begin
				if (a_line[0] == b_line[0])
					n_ties++;
				pick_a = (a_line[0] <= b_line[0]);
				pick_b = !pick_a;
			end
		end
		CMD_DEQ_A: begin
			if (a_line.size() == 0)
				r.st = ST_EMPTY;
			else
				pick_a = 1'b1;
		end
		default: begin
			if (b_line.size() == 0)
				r.st = ST_EMPTY;
			else
				pick_b = 1'b1;
		end
		endcase
		if (pick_a) begin
			r.rclass = CLASS_A;
			r.stamp  = a_line.pop_front();
		end else if (pick_b) begin
			r.rclass = CLASS_B;
			r.stamp  = b_line.pop_front();
		end
		case (r.st)
		ST_FULL:  n_dropped++;
		ST_EMPTY: n_empty++;
		default: begin
			if (op == CMD_ENQ)
				n_stored++;
			else
				n_popped++;
		end
		endcase
		return r;
	endfunction

	// first few faults in full, the rest only counted
	function automatic void log_fault(string msg);
		fault_count++;
		if (fault_count <= MAX_REPORTS)
			$display("[%0t] FAULT %0d: %s", $realtime, fault_count, msg);
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	// Idling and the drain pause are fixed by the position in the backlog,
	// so each phase boundary gets a full drain before it starts.
	task automatic add_cmd(cmd_t op, logic cls, logic [STAMP_W-1:0] stamp);
		queue_cmd_t  c;
		int unsigned pos;
		pos          = cmd_backlog.size();
		c.op         = op;
		c.cls        = cls;
		c.stamp      = stamp;
		c.idle_pct   = (pos < PHASE1_START) ? IDLE_PCT_P0 :
		               (pos < PHASE2_START) ? IDLE_PCT_P1 : IDLE_PCT_P2;
		c.wait_drain = (pos == PHASE1_START) || (pos == PHASE2_START);
		cmd_backlog.push_back(c);
	endtask

	function automatic logic [STAMP_W-1:0] make_date();
		int unsigned y;
		int unsigned m;
		int unsigned d;
		y = $urandom_range(9999, 1900);
		m = $urandom_range(12, 1);
		d = $urandom_range(28, 1);
		return STAMP_W'(y * 10000 + m * 100 + d);
	endfunction

	// Mostly plausible dates; a tight pool and repeats give equal heads,
	// plus the extremes and raw 27-bit noise.
	function automatic logic [STAMP_W-1:0] pick_stamp(logic [STAMP_W-1:0] last);
		logic [STAMP_W-1:0] raw;
		int unsigned        roll;
		roll = $urandom_range(99);
		raw  = STAMP_W'($urandom);
		if (roll < 50)
			return make_date();
		else if (roll < 65)
			return STAMP_W'(27'd20200101 + $urandom_range(2));
		else if (roll < 75)
			return last;
		else if (roll < 79)
			return '0;
		else if (roll < 83)
			return STAMP_MAX_DATE;
		else if (roll < 86)
			return STAMP_ALL_ONES;
		else
			return raw;
	endfunction

	// ------------------------------------------------------------------
	// Driver: presents the next command on the falling edge. A command
	// stays up until taken; the phase's idle rate and any drain pause are
	// only applied between transactions.
	// ------------------------------------------------------------------
	always @(negedge clk) begin : drive_cmd
		queue_cmd_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && !cmd_taken) begin
			// still waiting for busy to drop: hold everything
		end else if (cmd_backlog.size() == 0) begin
			start <= 1'b0;
		end else if (cmd_backlog[0].wait_drain && expected_results.size() != 0) begin
			start <= 1'b0;
		end else if ($urandom_range(99) < cmd_backlog[0].idle_pct) begin
			start <= 1'b0;
		end else begin
			nxt           = cmd_backlog.pop_front();
			start         <= 1'b1;
			command       <= nxt.op;
			entry_class   <= nxt.cls;
			arrival_stamp <= nxt.stamp;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: on the rising edge, check the result transaction against
	// the oldest expectation, then book the command taken at this edge.
	// Results cannot be held off, so done is checked every cycle.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : watch_results
		queue_result_t want;
		if (!arst_n) begin
			cmd_taken = 1'b0;
		end else begin
			cmd_taken = start && !busy;
			if (done) begin
				n_results++;
				if (expected_results.size() == 0) begin
					log_fault($sformatf("result with nothing outstanding: class %0d stamp %0d status %0d",
						result_class, result_stamp, status));
				end else begin
					want = expected_results.pop_front();
					if (result_class !== want.rclass || result_stamp !== want.stamp ||
							status !== want.st)
						log_fault($sformatf({"result %0d: class exp %0d got %0d, ",
							"stamp exp %0d got %0d, status exp %s got %0d"},
							n_results, want.rclass, result_class, want.stamp, result_stamp,
							want.st.name(), status));
				end
			end
			if (cmd_taken) begin
				n_cmds++;
				expected_results.push_back(predict_queue_op(cmd_t'(command), entry_class,
					arrival_stamp));
			end
			if (cmd_taken || done)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[%0t] watchdog: %0d cycles without a transaction, %0d outstanding",
					$realtime, idle_cycles, expected_results.size());
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus, reset and end of run
	// ------------------------------------------------------------------
	initial begin : run_test
		logic [STAMP_W-1:0] last_stamp;
		logic               fav_cls;
		int unsigned        mode;
		int unsigned        roll;
		logic [STAMP_W-1:0] noise;

		// Directed opening.
		// Empty queues on every dequeue flavour.
		add_cmd(CMD_DEQ_ANY, ENTRY_A, '0);
		add_cmd(CMD_DEQ_A,   ENTRY_B, STAMP_ALL_ONES);
		add_cmd(CMD_DEQ_B,   ENTRY_A, '0);
		// Equal heads: class A must win, then B is the lone non-empty queue.
		add_cmd(CMD_ENQ,     ENTRY_A, '0);
		add_cmd(CMD_ENQ,     ENTRY_B, '0);
		add_cmd(CMD_DEQ_ANY, ENTRY_B, STAMP_ALL_ONES);
		add_cmd(CMD_DEQ_ANY, ENTRY_A, '0);
		// Stamp beyond the date range compares as a plain 27-bit value.
		add_cmd(CMD_ENQ,     ENTRY_A, STAMP_ALL_ONES);
		add_cmd(CMD_ENQ,     ENTRY_B, STAMP_MAX_DATE);
		add_cmd(CMD_DEQ_ANY, ENTRY_A, '0);
		// Fill class A to the brim, then overflow it.
		repeat (QUEUE_DEPTH - 1)
			add_cmd(CMD_ENQ, ENTRY_A, make_date());
		add_cmd(CMD_ENQ, ENTRY_A, STAMP_MAX_DATE);

		// Random part: bursts that fill, drain or mix, so both queues keep
		// going full and empty while stamps collide often enough for ties.
		last_stamp = STAMP_MAX_DATE;
		mode       = 0;
		fav_cls    = ENTRY_A;
		while (cmd_backlog.size() < TOTAL_CMDS) begin
			if (cmd_backlog.size() % 40 == 0) begin
				mode    = $urandom_range(2);
				fav_cls = 1'($urandom_range(1));
			end
			roll  = $urandom_range(99);
			noise = STAMP_W'($urandom);
			if (roll < ((mode == 0) ? 70 : (mode == 1) ? 25 : 50)) begin
				last_stamp = pick_stamp(last_stamp);
				add_cmd(CMD_ENQ,
					($urandom_range(99) < ((mode == 2) ? 50 : 75)) ? fav_cls : !fav_cls,
					last_stamp);
			end else begin
				roll = $urandom_range(99);
				add_cmd((roll < 50) ? CMD_DEQ_ANY : (roll < 75) ? CMD_DEQ_A : CMD_DEQ_B,
					1'($urandom_range(1)), noise);
			end
		end

		// Reset once, released on a falling edge.
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Sampling on the falling edge keeps clear of the posedge bookkeeping.
		do
			@(negedge clk);
		while (cmd_backlog.size() != 0 || start || expected_results.size() != 0);
		repeat (END_SETTLE) @(posedge clk);

		if (expected_results.size() != 0)
			log_fault($sformatf("%0d results never arrived", expected_results.size()));

		$display("Run: %0d commands, %0d results; enqueues stored %0d, dropped full %0d",
			n_cmds, n_results, n_stored, n_dropped);
		$display("     dequeues served %0d, empty %0d, equal-head picks %0d, faults %0d",
			n_popped, n_empty, n_ties, fault_count);
		if (fault_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
